[hw/rtl/fci_pkg.sv]
// fci_pkg: shared types, curve constants and helpers for the fan curve interpolator
// used by fci_ctrl, fci_dp and fan_curve_interpolator; depends on nothing

package fci_pkg;

  // curve breakpoints: whole degrees and duty on a 0..255 scale
  localparam int unsigned CURVE_POINTS = 12;
  localparam int unsigned SEG_IDX_W    = $clog2(CURVE_POINTS);
  localparam int unsigned CENTI_PER_DEG = 100;
  localparam int unsigned DUTY_FULL    = 255;

  localparam logic [7:0] CURVE_DEG [CURVE_POINTS] = '{
    8'd35, 8'd36, 8'd38, 8'd40, 8'd42, 8'd44,
    8'd46, 8'd47, 8'd49, 8'd51, 8'd53, 8'd55
  };

  localparam logic [7:0] CURVE_DUTY [CURVE_POINTS] = '{
    8'd0,   8'd70,  8'd105, 8'd120, 8'd135, 8'd155,
    8'd165, 8'd180, 8'd190, 8'd205, 8'd230, 8'd255
  };

  // widths of the datapath
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned RELOAD_W = 16;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned ACC_W   = TEMP_W + DUTY_W;   // duty times segment length
  localparam int unsigned DIV_DW  = ACC_W + 1;         // dividend width
  localparam int unsigned DIV_VW  = TEMP_W + 1;        // divisor width
  localparam int unsigned DIV_CNT_W = $clog2(DIV_DW + 1);

  // reciprocal of 255, exact for products below the saturation point
  localparam logic [15:0] RECIP_255   = 16'h8081;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned CMP_SAT_MIN = DUTY_FULL * 256;  // quotient exceeds 255 from here

  // breakpoint position in centidegrees
  function automatic logic [TEMP_W-1:0] point_centi(logic [SEG_IDX_W-1:0] idx);
    logic [TEMP_W-1:0] deg;
    deg = TEMP_W'(CURVE_DEG[idx]);
    return TEMP_W'(deg * TEMP_W'(CENTI_PER_DEG));
  endfunction

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SEARCH,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_INT,
    ST_WAIT_INT,
    ST_SCALE,
    ST_COMPARE,
    ST_DONE
  } state_e;

  // where the duty register takes its next value from
  typedef enum logic [2:0] {
    DUTY_HOLD,
    DUTY_FIRST,
    DUTY_LAST,
    DUTY_ZERO,
    DUTY_QUOT
  } duty_src_e;

  typedef struct packed {
    logic      load;
    logic      seg_step;
    logic      mul_lo;
    logic      mul_hi;
    logic      div_go;
    duty_src_e duty_src;
    logic      scale;
    logic      cmp_load;
    logic      out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic below_first;
    logic above_last;
    logic seg_hit;
    logic seg_last;
    logic div_done;
    logic out_free;
  } ctl_sts_t;

endpackage

[hw/rtl/fci_ctrl.sv]
// fci_ctrl: sequencing state machine for the fan curve interpolator
// depends on fci_pkg; drives fci_dp through ctl_cmd_t and reads ctl_sts_t

module fci_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fci_pkg::ctl_sts_t sts_i,
  output fci_pkg::ctl_cmd_t cmd_o
);

  fci_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fci_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.duty_src = fci_pkg::DUTY_HOLD;
    unique case (state_q)
      fci_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fci_pkg::ST_CLAMP;
        end
      end
      fci_pkg::ST_CLAMP: begin
        if (sts_i.below_first) begin
          cmd_o.duty_src = fci_pkg::DUTY_FIRST;
          state_d        = fci_pkg::ST_SCALE;
        end else if (sts_i.above_last) begin
          cmd_o.duty_src = fci_pkg::DUTY_LAST;
          state_d        = fci_pkg::ST_SCALE;
        end else begin
          state_d = fci_pkg::ST_SEARCH;
        end
      end
      // walk the segments one per cycle
      fci_pkg::ST_SEARCH: begin
        if (sts_i.seg_hit) begin
          state_d = fci_pkg::ST_MUL_LO;
        end else if (sts_i.seg_last) begin
          cmd_o.duty_src = fci_pkg::DUTY_ZERO;
          state_d        = fci_pkg::ST_SCALE;
        end else begin
          cmd_o.seg_step = 1'b1;
        end
      end
      fci_pkg::ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = fci_pkg::ST_MUL_HI;
      end
      fci_pkg::ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = fci_pkg::ST_DIV_INT;
      end
      fci_pkg::ST_DIV_INT: begin
        cmd_o.div_go = 1'b1;
        state_d      = fci_pkg::ST_WAIT_INT;
      end
      fci_pkg::ST_WAIT_INT: begin
        if (sts_i.div_done) begin
          cmd_o.duty_src = fci_pkg::DUTY_QUOT;
          state_d        = fci_pkg::ST_SCALE;
        end
      end
      fci_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = fci_pkg::ST_COMPARE;
      end
      // compare value from the reload product
      fci_pkg::ST_COMPARE: begin
        cmd_o.cmp_load = 1'b1;
        state_d        = fci_pkg::ST_DONE;
      end
      // hand the result to the output register once it is free
      fci_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = fci_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fci_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/fci_dp.sv]
// fci_dp: datapath of the fan curve interpolator: segment walk, multiplies,
// restoring divider, reciprocal scaling, reload and output registers; depends on fci_pkg

module fci_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fci_pkg::ctl_cmd_t               cmd_i,
  output fci_pkg::ctl_sts_t               sts_o,
  input  logic [fci_pkg::TEMP_W-1:0]      temp_i,
  input  logic                            cfg_we_i,
  input  logic [fci_pkg::RELOAD_W-1:0]    cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fci_pkg::DUTY_W-1:0]      out_duty_o,
  output logic [fci_pkg::DUTY_W-1:0]      out_cmp_o
);

  localparam int unsigned TW  = fci_pkg::TEMP_W;
  localparam int unsigned KW  = fci_pkg::SEG_IDX_W;
  localparam int unsigned DW  = fci_pkg::DIV_DW;
  localparam int unsigned VW  = fci_pkg::DIV_VW;
  localparam int unsigned AW  = fci_pkg::ACC_W;
  localparam int unsigned YW  = fci_pkg::DUTY_W;
  localparam int unsigned CW  = fci_pkg::DIV_CNT_W;
  localparam logic [KW-1:0] LAST_PT  = KW'(fci_pkg::CURVE_POINTS - 1);
  localparam logic [KW-1:0] LAST_SEG = KW'(fci_pkg::CURVE_POINTS - 2);

  logic [TW-1:0]   temp_q;
  logic [KW-1:0]   seg_q;
  logic [KW-1:0]   seg_next;
  logic [TW-1:0]   seg_lo, seg_hi, seg_len, seg_off;
  logic [AW-1:0]   acc_q;
  logic [AW-1:0]   prod_q;
  logic [YW-1:0]   duty_q;
  logic [YW-1:0]   quot_sat;
  logic [YW-1:0]   cmp_q;
  logic [31:0]     recip_prod;
  logic [fci_pkg::RELOAD_W-1:0] reload_q;

  logic [DW-1:0]   div_quot_q;
  logic [VW-1:0]   div_rem_q;
  logic [VW-1:0]   div_dvs_q;
  logic [CW-1:0]   div_cnt_q;
  logic            div_busy_q;
  logic            div_done_q;
  logic [VW:0]     div_shift;
  logic            div_ge;

  logic            out_valid_q;
  logic [YW-1:0]   out_duty_q, out_cmp_q;

  // current segment bounds
  assign seg_next = seg_q + KW'(1);
  assign seg_lo   = fci_pkg::point_centi(seg_q);
  assign seg_hi   = fci_pkg::point_centi(seg_next);
  assign seg_len  = seg_hi - seg_lo;
  assign seg_off  = temp_q - seg_lo;

  // status toward the controller
  assign sts_o.below_first = temp_q <= fci_pkg::point_centi(KW'(0));
  assign sts_o.above_last  = temp_q >= fci_pkg::point_centi(LAST_PT);
  assign sts_o.seg_hit     = (seg_hi > seg_lo) && (temp_q >= seg_lo) && (temp_q <= seg_hi);
  assign sts_o.seg_last    = seg_q == LAST_SEG;
  assign sts_o.div_done    = div_done_q;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  // quotient saturated to eight bits
  assign quot_sat = (|div_quot_q[DW-1:YW]) ? {YW{1'b1}} : div_quot_q[YW-1:0];

  // input capture and segment index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      temp_q <= temp_i;
      seg_q  <= '0;
    end else if (cmd_i.seg_step) begin
      seg_q <= seg_next;
    end
  end

  // weighted sum of the two end duties, one product per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      acc_q <= AW'(fci_pkg::CURVE_DUTY[seg_q]) * AW'(seg_len - seg_off);
    end else if (cmd_i.mul_hi) begin
      acc_q <= acc_q + AW'(fci_pkg::CURVE_DUTY[seg_next]) * AW'(seg_off);
    end
  end

  // duty register
  always_ff @(posedge clk_i) begin
    case (cmd_i.duty_src)
      fci_pkg::DUTY_FIRST: duty_q <= fci_pkg::CURVE_DUTY[0];
      fci_pkg::DUTY_LAST:  duty_q <= fci_pkg::CURVE_DUTY[LAST_PT];
      fci_pkg::DUTY_ZERO:  duty_q <= '0;
      fci_pkg::DUTY_QUOT:  duty_q <= quot_sat;
      default:             duty_q <= duty_q;
    endcase
  end

  // duty times reload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      prod_q <= AW'(duty_q) * AW'(reload_q);
    end
  end

  // floor of the product over 255 by reciprocal, saturated at 255
  assign recip_prod = 32'(prod_q[15:0]) * 32'(fci_pkg::RECIP_255);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_load) begin
      cmp_q <= (prod_q >= AW'(fci_pkg::CMP_SAT_MIN)) ? {YW{1'b1}}
                                                     : recip_prod[fci_pkg::RECIP_SHIFT +: YW];
    end
  end

  // reload register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= fci_pkg::RELOAD_W'(fci_pkg::DUTY_FULL);
    end else if (cfg_we_i) begin
      reload_q <= cfg_wdata_i;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign div_shift = {div_rem_q, div_quot_q[DW-1]};
  assign div_ge    = div_shift >= {1'b0, div_dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      div_rem_q  <= '0;
      div_quot_q <= {acc_q, 1'b0} + DW'(seg_len);
      div_dvs_q  <= {seg_len, 1'b0};
    end else if (div_busy_q) begin
      div_quot_q <= {div_quot_q[DW-2:0], div_ge};
      div_rem_q  <= div_ge ? VW'(div_shift - {1'b0, div_dvs_q}) : div_shift[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      div_done_q <= div_busy_q && (div_cnt_q == CW'(1));
      if (cmd_i.div_go) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= CW'(DW);
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - CW'(1);
        if (div_cnt_q == CW'(1)) begin
          div_busy_q <= 1'b0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_duty_q <= duty_q;
      out_cmp_q  <= cmp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_duty_o  = out_duty_q;
  assign out_cmp_o   = out_cmp_q;

endmodule

[hw/rtl/fan_curve_interpolator.sv]
// Fan curve interpolator: maps a temperature in centidegrees through a
// 12-point fan curve to a duty level and a PWM compare value.
// Input beat on s_axis: tdata[15:0] = temperature in 0.01 degrees C.
// Output beat on m_axis: tdata[7:0] = duty level, tdata[15:8] = compare value.
// cfg_we_i/cfg_wdata_i write the 16-bit timer reload; write only while idle.
// One item at a time: s_axis_tready is high only while the controller idles.
// Below or above the curve an item skips to the reload product; on the curve
// it first passes a segment walk of one segment per cycle, two multiplies
// and a restoring divider for the interpolation. Then come the reload
// product and the scaling by a reciprocal of 255.
// A new item is taken only once the last one has been handed to the output
// register.
// A finished result sits in the output register; the next input beat is
// taken while it waits, and if the receiver still stalls when that item is
// done, the controller holds it until the output register frees.
// Reset clears the controller, divider and output valid and sets the timer
// reload to 255.

module fan_curve_interpolator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] temp_centideg
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] duty_level, [15:8] compare_value
);

  fci_pkg::ctl_cmd_t cmd;
  fci_pkg::ctl_sts_t sts;
  logic [fci_pkg::DUTY_W-1:0] duty, cmp;

  // sequencer
  fci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  fci_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .temp_i      (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_duty_o  (duty),
    .out_cmp_o   (cmp)
  );

  assign m_axis_tdata = {cmp, duty};

endmodule

[hw/rtl/fci_checker.sv]
// fci_checker: port-level assertions for fan_curve_interpolator
// bound to the top level below; uses no package

module fci_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // output beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  // one item at a time: no input right after an accepted beat
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // a new result appears only while the input side was busy
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while idle");

  // zero duty always gives zero compare value
  a_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:0] == 8'd0) |-> m_axis_tdata[15:8] == 8'd0)
    else $error("nonzero compare value with zero duty");

endmodule

bind fan_curve_interpolator fci_checker u_fci_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[test/fci_curve_checker.sv]
// fci_curve_checker: watches the config port and both streams of the fan curve
// interpolator, predicts duty and compare value per temperature, compares results
// depends on nothing but the port widths of fan_curve_interpolator
`timescale 1ns / 1ps

module fci_curve_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,    // [15:0] temp_centideg
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,    // [7:0] duty_level, [15:8] compare_value
  output int          outstanding_o,
  output int          mismatches_o
);

  localparam int unsigned KNEES = 12;

  // fan curve knees: whole degrees and duty
  localparam int unsigned KNEE_DEG [KNEES] = '{
    35, 36, 38, 40, 42, 44, 46, 47, 49, 51, 53, 55
  };
  localparam int unsigned KNEE_DUTY [KNEES] = '{
    0, 70, 105, 120, 135, 155, 165, 180, 190, 205, 230, 255
  };

  typedef struct packed {
    logic [7:0] compare_value;
    logic [7:0] duty_level;
  } fan_result_t;

  fan_result_t   fan_expected_q [$];
  logic [15:0]   reload_shadow = 16'd255;
  int            mismatches = 0;

  assign mismatches_o = mismatches;

  // interpolated duty, rounded half up
  function automatic logic [7:0] curve_duty_of(input logic [15:0] temp);
    int unsigned lo, hi, span, ofs, num, q;
    if (temp <= KNEE_DEG[0] * 100) return 8'(KNEE_DUTY[0]);
    if (temp >= KNEE_DEG[KNEES-1] * 100) return 8'(KNEE_DUTY[KNEES-1]);
    for (int k = 0; k < KNEES - 1; k++) begin
      lo = KNEE_DEG[k] * 100;
      hi = KNEE_DEG[k+1] * 100;
      if (hi > lo && temp >= lo && temp <= hi) begin
        span = hi - lo;
        ofs  = temp - lo;
        num  = KNEE_DUTY[k] * (span - ofs) + KNEE_DUTY[k+1] * ofs;
        q    = (2 * num + span) / (2 * span);
        if (q > 255) q = 255;
        return q[7:0];
      end
    end
    return 8'd0;
  endfunction

  // duty scaled by the timer reload, floored and saturated
  function automatic logic [7:0] compare_of(input logic [7:0] duty, input logic [15:0] reload);
    int p;
    p = (int'(duty) * int'(reload)) / 255;
    if (p > 255) p = 255;
    return p[7:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // compare each output beat with the oldest prediction, then predict new beats
  always @(posedge clk_i or negedge rst_ni) begin
    fan_result_t want;
    fan_result_t got;
    if (!rst_ni) begin
      reload_shadow = 16'd255;
      fan_expected_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (fan_expected_q.size() == 0) begin
          report_mismatch($sformatf("output beat %h with nothing expected", m_tdata_i));
        end else begin
          want = fan_expected_q.pop_front();
          if (got.duty_level !== want.duty_level)
            report_mismatch($sformatf("duty_level %h, expected %h",
                                      got.duty_level, want.duty_level));
          if (got.compare_value !== want.compare_value)
            report_mismatch($sformatf("compare_value %h, expected %h",
                                      got.compare_value, want.compare_value));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        want.duty_level    = curve_duty_of(s_tdata_i);
        want.compare_value = compare_of(want.duty_level, reload_shadow);
        fan_expected_q.push_back(want);
      end
      if (cfg_we_i) reload_shadow = cfg_wdata_i;
    end
    outstanding_o <= fan_expected_q.size();
  end

endmodule

[test/tb_fan_curve_interpolator.sv]
// tb_fan_curve_interpolator: clock, reset, temperature stimulus, receiver stalls
// and reload writes for fan_curve_interpolator; fci_curve_checker does the checking
// depends on fci_pkg, fan_curve_interpolator and fci_curve_checker
`timescale 1ns / 1ps

module tb_fan_curve_interpolator;

  localparam int BLOCKS       = 15;
  localparam int BLOCK_ITEMS  = 130;
  localparam int HOLD_CYCLES  = 500;
  localparam int SETTLE       = 8;
  localparam int TAIL_CYCLES  = 80;
  localparam int IDLE_LOW     = 24;
  localparam int IDLE_HIGH    = 68;

  localparam logic [15:0] CORNER_TEMPS [24] = '{
    16'd0, 16'd65535, 16'd3499, 16'd3500, 16'd3501, 16'd3550,
    16'd3600, 16'd3620, 16'd3800, 16'd4000, 16'd4200, 16'd4400,
    16'd4600, 16'd4700, 16'd4900, 16'd5100, 16'd5300, 16'd5499,
    16'd5500, 16'd5501, 16'd4650, 16'd4333, 16'h5555, 16'hAAAA
  };

  // reload per block; the last blocks take random values
  localparam logic [15:0] RELOAD_STEPS [12] = '{
    16'd0, 16'd65535, 16'd1, 16'd254, 16'd256, 16'd128,
    16'd510, 16'd65534, 16'd255, 16'd1000, 16'd3, 16'd300
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int tx_idle_pct = IDLE_LOW;
  int rx_idle_pct = IDLE_HIGH;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int outstanding;
  int mismatches;

  fan_curve_interpolator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fci_curve_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit, well above the slowest correct run
  initial begin
    #10ms;
    $display("fan_curve_interpolator regression: fail");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off whenever a new ticket shows up
  always @(posedge clk_i) begin
    if (hold_seen != hold_ticket) begin
      hold_seen     <= hold_ticket;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // mostly temperatures on the curve, some at knees, some anywhere
  function automatic logic [15:0] pick_temp();
    int roll, v;
    roll = $urandom_range(99);
    if (roll < 65) begin
      v = $urandom_range(5600, 3400);
    end else if (roll < 80) begin
      v = int'(fci_pkg::CURVE_DEG[$urandom_range(fci_pkg::CURVE_POINTS - 1)]) * 100
          + int'($urandom_range(2)) - 1;
    end else begin
      v = $urandom_range(65535);
    end
    return v[15:0];
  endfunction

  // offer one temperature beat, with random gaps before it
  task automatic send_temp(input logic [15:0] temp);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 16'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= temp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reload(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners of the curve at the reset reload
    foreach (CORNER_TEMPS[i]) send_temp(CORNER_TEMPS[i]);

    for (int b = 0; b < BLOCKS; b++) begin
      drain();
      repeat (SETTLE) @(posedge clk_i);
      write_reload(b < 12 ? RELOAD_STEPS[b] : 16'($urandom));
      // sender light / receiver heavy, then swapped, then free running
      if (b < 5) begin
        tx_idle_pct = IDLE_LOW;
        rx_idle_pct = IDLE_HIGH;
      end else if (b < 10) begin
        tx_idle_pct = IDLE_HIGH;
        rx_idle_pct = IDLE_LOW;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long receiver hold-off while beats keep coming
      if (b == 11) hold_ticket <= hold_ticket + 1;
      for (int n = 0; n < BLOCK_ITEMS; n++) send_temp(pick_temp());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("fan_curve_interpolator regression: pass");
    end else begin
      $display("fan_curve_interpolator regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fci_pkg.sv
hw/rtl/fci_ctrl.sv
hw/rtl/fci_dp.sv
hw/rtl/fan_curve_interpolator.sv
hw/rtl/fci_checker.sv
test/fci_curve_checker.sv
test/tb_fan_curve_interpolator.sv
